// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

  // Field widths of the command and result transfers.
  localparam int unsigned SIZE_FIELD_W  = 16;
  localparam int unsigned INDEX_FIELD_W = 4;

  // Function codes carried in the command.
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // One command: load a block size, or request an allocation.
  typedef struct packed {
    logic                    func;
    logic [SIZE_FIELD_W-1:0] size;
  } bfa_cmd_t;

  // One allocation result.
  typedef struct packed {
    logic                     granted;
    logic [INDEX_FIELD_W-1:0] block_index;
    logic [SIZE_FIELD_W-1:0]  remaining_after;
  } bfa_res_t;

endpackage

// ===== hdl/bfa_table.sv =====
module bfa_table #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bfa_scan.sv =====
module bfa_scan #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             valid,
  input  logic [IDX_W-1:0] idx,
  input  logic [WIDTH-1:0] data,
  input  logic [WIDTH-1:0] req,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output logic [WIDTH-1:0] best_val
);

  logic hit;

  // The entry fits and is strictly smaller than the best so far, so ties keep the lower index.
  assign hit = valid && (data >= req) && (!found || (data < best_val));

  // Found flag is control state.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (hit) begin
      found <= 1'b1;
    end
  end

  // Best candidate so far.
  always_ff @(posedge clk) begin
    if (hit) begin
      best_idx <= idx;
      best_val <= data;
    end
  end

endmodule

// ===== hdl/best_fit_block_allocator_top.sv =====
// Best-fit block allocator.
// Commands arrive on cmd and are transferred at a rising edge where start is
// high and busy is low. A load command (func = FUNC_LOAD) appends cmd.size to
// the block table and gives no result; loads into a full table
// are dropped. A request command (func = FUNC_REQUEST) scans the loaded blocks
// one per cycle through the single table read port and a shared compare unit,
// picks the smallest block that still holds at least the requested size
// (lowest index on a tie) and subtracts the request from it.
// A request on an empty table answers in the next cycle; otherwise the scan
// reads the block_count loaded entries in S_SCAN, S_DRAIN holds the last
// compare and S_FINISH does the write-back, after which done rises. busy is
// high meanwhile.
// The result appears on res for exactly one cycle, flagged by done; the
// receiver cannot stall it, and it must take the transfer in that cycle.
// Reset empties the table (block count back to zero) and returns to idle; no
// clearing pass is needed, as only loaded entries are ever read.
module best_fit_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bfa_pkg::bfa_cmd_t cmd,
  output logic              done,
  output bfa_pkg::bfa_res_t res
);

  import bfa_pkg::*;

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       addr;
  logic [SIZE_WIDTH-1:0]  req_size;
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_idx;
  logic [SIZE_WIDTH-1:0]  rd_data;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [SIZE_WIDTH-1:0]  best_val;
  logic [SIZE_WIDTH-1:0]  new_val;
  logic                   accept;
  logic                   do_load;
  logic                   do_req;
  logic                   last_addr;
  logic [SIZE_WIDTH+SIZE_FIELD_W-1:0]   size_ext;
  logic [SIZE_WIDTH-1:0]                size_in;
  logic [IDX_W+INDEX_FIELD_W-1:0]       idx_ext;
  logic [SIZE_WIDTH+SIZE_FIELD_W-1:0]   rem_ext;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [SIZE_WIDTH-1:0]  wdata;

  // Command decode; the size is taken modulo 2^SIZE_WIDTH.
  assign accept   = start && !busy;
  assign do_load  = accept && (cmd.func == FUNC_LOAD);
  assign do_req   = accept && (cmd.func == FUNC_REQUEST);
  assign size_ext = {{SIZE_WIDTH{1'b0}}, cmd.size};
  assign size_in  = size_ext[SIZE_WIDTH-1:0];
  assign busy     = (state != S_IDLE);

  // Scan ends when the last loaded entry has been addressed.
  assign last_addr = ((CNT_W + 1)'(addr) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (do_req && (count != '0)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_addr) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == S_SCAN);
      if (do_load && (count < CNT_W'(NUM_BLOCKS))) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Scan address, request size and read tag.
  always_ff @(posedge clk) begin
    if (do_req) begin
      req_size <= size_in;
      addr     <= '0;
    end else if (state == S_SCAN) begin
      addr <= addr + IDX_W'(1);
    end
    rd_idx <= addr;
  end

  // Write port: loads append, the write-back stores the reduced block.
  assign new_val = best_val - req_size;
  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = size_in;
    if (state == S_FINISH) begin
      we    = found;
      waddr = best_idx;
      wdata = new_val;
    end else if (do_load && (count < CNT_W'(NUM_BLOCKS))) begin
      we = 1'b1;
    end
  end

  bfa_table #(
    .DEPTH  (NUM_BLOCKS),
    .WIDTH  (SIZE_WIDTH),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (state == S_SCAN),
    .raddr (addr),
    .rdata (rd_data)
  );

  bfa_scan #(
    .WIDTH (SIZE_WIDTH),
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (do_req),
    .valid    (rd_valid),
    .idx      (rd_idx),
    .data     (rd_data),
    .req      (req_size),
    .found    (found),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  // Result register.
  assign idx_ext = {{INDEX_FIELD_W{1'b0}}, best_idx};
  assign rem_ext = {{SIZE_FIELD_W{1'b0}}, new_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FINISH) || (do_req && (count == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && found) begin
      res.granted         <= 1'b1;
      res.block_index     <= idx_ext[INDEX_FIELD_W-1:0];
      res.remaining_after <= rem_ext[SIZE_FIELD_W-1:0];
    end else if (state == S_FINISH || do_req) begin
      res.granted         <= 1'b0;
      res.block_index     <= '0;
      res.remaining_after <= '0;
    end
  end

  // A result strobe only follows a write-back or a request on an empty table.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH) ||
             $past(start && !busy && cmd.func == FUNC_REQUEST && count == '0))
    else $error("result strobe without a finished request");

  // The strobe always lands while the sequencer is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while busy");

  // Table data only returns during a scan or its drain cycle.
  a_read_window: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("read data outside the scan");

  // A load into a full table leaves the count alone.
  a_full_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.func == FUNC_LOAD && count == CNT_W'(NUM_BLOCKS))
      |=> $stable(count))
    else $error("block count grew past the table");

endmodule
